// File: src/che_pkg.sv
// Shared widths, constants and the output saturation function of the Hermite evaluator.
package che_pkg;

    localparam int D_W     = 32;
    localparam int T_W     = 16;
    localparam int N_OPS   = 4;
    localparam int IN_W    = ((N_OPS * D_W + T_W + 7) / 8) * 8;
    localparam int OUT_W   = 2 * D_W;
    localparam int T2_W    = 2 * T_W;
    localparam int T3_W    = 3 * T_W;
    localparam int FRAC_T  = 15;
    localparam int VAL_SH  = 3 * FRAC_T;
    localparam int SLP_SH  = 2 * FRAC_T;
    localparam int WW      = 52;
    localparam int LO_W    = WW / 2;
    localparam int HI_W    = WW - LO_W;
    localparam int PLO_W   = LO_W + 1 + D_W;
    localparam int PHI_W   = HI_W + D_W;
    localparam int PW      = WW + D_W;
    localparam int SUM2_W  = PW + 1;
    localparam int SW      = PW + 2;
    localparam int SHV_W   = SW - VAL_SH;
    localparam int SAT_W   = SW - SLP_SH;
    localparam int STAGES  = 8;

    localparam logic [WW-1:0] ONE_VAL = WW'(1) << VAL_SH;
    localparam logic [WW-1:0] ONE_SLP = WW'(1) << SLP_SH;
    localparam logic signed [SW-1:0] HALF_VAL = SW'(1) << (VAL_SH - 1);
    localparam logic signed [SW-1:0] HALF_SLP = SW'(1) << (SLP_SH - 1);

    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32'sh7fff_ffff);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-33'sd2147483648);

    function automatic logic [D_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic [D_W-1:0] r;
        if (x > SAT_MAX)
            r = SAT_MAX[D_W-1:0];
        else if (x < SAT_MIN)
            r = SAT_MIN[D_W-1:0];
        else
            r = x[D_W-1:0];
        return r;
    endfunction

endpackage

// File: src/cubic_hermite_eval_unit.sv
// Top level: pipelined cubic Hermite position and slope evaluation for one axis.
//
// Input stream s_*: one beat carries start point, start tangent, end tangent,
// end point (signed Q16.16) and t (unsigned Q1.15). Output stream m_*: one beat
// per input beat, curve value and slope (signed Q16.16, rounded half up,
// saturated to 32 bits), in input order.
// m_tvalid rises once an accepted beat has passed the register stages. While the
// output side is not stalled, a new beat is accepted every cycle; throughput is
// one beat per cycle through eight register stages (input capture with t
// square, t cube, weight forming, split 26x32 partial products, product merge,
// pair sums, final sum with rounding, saturation).
// When m_tvalid is high and m_tready is low, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. s_tready depends on m_tready.
// Reset clears all stage valid bits; the data path needs no reset.
module cubic_hermite_eval_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [31:0] start_point, [63:32] start_tangent, [95:64] end_tangent,
    // [127:96] end_point, [143:128] t_param
    input  logic [che_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [31:0] curve_value, [63:32] curve_slope
    output logic [che_pkg::OUT_W-1:0] m_tdata
);
    import che_pkg::*;

    logic                      ce;
    logic [STAGES-1:0]         v_reg;

    logic signed [D_W-1:0]     op1_reg [N_OPS];
    logic signed [D_W-1:0]     op2_reg [N_OPS];
    logic signed [D_W-1:0]     op3_reg [N_OPS];
    logic [T_W-1:0]            t1_reg;
    logic [T_W-1:0]            t2s_reg;
    logic [T2_W-1:0]           tsq1_reg;
    logic [T2_W-1:0]           tsq2_reg;
    logic [T3_W-1:0]           tcu_reg;
    logic [T2_W-1:0]           tsq_next;
    logic [T3_W-1:0]           tcu_next;

    logic [WW-1:0]             w_next [2*N_OPS];
    logic [WW-1:0]             w_reg  [2*N_OPS];
    logic signed [PLO_W-1:0]   plo_next [2*N_OPS];
    logic signed [PLO_W-1:0]   plo_reg  [2*N_OPS];
    logic signed [PHI_W-1:0]   phi_next [2*N_OPS];
    logic signed [PHI_W-1:0]   phi_reg  [2*N_OPS];
    logic signed [PW-1:0]      prod_next [2*N_OPS];
    logic signed [PW-1:0]      prod_reg  [2*N_OPS];
    logic signed [SUM2_W-1:0]  pair_next [N_OPS];
    logic signed [SUM2_W-1:0]  pair_reg  [N_OPS];
    logic signed [SW-1:0]      sum_v;
    logic signed [SW-1:0]      sum_d;
    logic signed [SHV_W-1:0]   shv_next;
    logic signed [SHV_W-1:0]   shv_reg;
    logic signed [SAT_W-1:0]   shd_next;
    logic signed [SAT_W-1:0]   shd_reg;
    logic [OUT_W-1:0]          out_next;
    logic [OUT_W-1:0]          out_reg;

    assign ce       = !v_reg[STAGES-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = v_reg[STAGES-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[STAGES-2:0], s_tvalid};
    end

    // t powers
    assign tsq_next = T2_W'(s_tdata[N_OPS*D_W +: T_W]) * T2_W'(s_tdata[N_OPS*D_W +: T_W]);
    assign tcu_next = T3_W'(tsq1_reg) * T3_W'(t1_reg);

    // basis weights: value in Q45, slope in Q30
    always_comb
    begin
        logic [WW-1:0] c3;
        logic [WW-1:0] s2;
        logic [WW-1:0] t30;
        logic [WW-1:0] sq;
        logic [WW-1:0] t15;
        c3  = WW'(tcu_reg);
        s2  = WW'(tsq2_reg) << FRAC_T;
        t30 = WW'(t2s_reg) << SLP_SH;
        sq  = WW'(tsq2_reg);
        t15 = WW'(t2s_reg) << FRAC_T;
        w_next[0] = (c3 << 1) - ((s2 << 1) + s2) + ONE_VAL;
        w_next[1] = c3 - (s2 << 1) + t30;
        w_next[2] = c3 - s2;
        w_next[3] = ((s2 << 1) + s2) - (c3 << 1);
        w_next[4] = ((sq << 2) + (sq << 1)) - ((t15 << 2) + (t15 << 1));
        w_next[5] = ((sq << 1) + sq) - (t15 << 2) + ONE_SLP;
        w_next[6] = ((sq << 1) + sq) - (t15 << 1);
        w_next[7] = ((t15 << 2) + (t15 << 1)) - ((sq << 2) + (sq << 1));
    end

    // split products, product merge and pair sums
    always_comb
    begin
        for (int k = 0; k < N_OPS; k++)
        begin
            plo_next[k]         = $signed({1'b0, w_reg[k][LO_W-1:0]}) * op3_reg[k];
            phi_next[k]         = $signed(w_reg[k][WW-1:LO_W]) * op3_reg[k];
            plo_next[k + N_OPS] = $signed({1'b0, w_reg[k + N_OPS][LO_W-1:0]}) * op3_reg[k];
            phi_next[k + N_OPS] = $signed(w_reg[k + N_OPS][WW-1:LO_W]) * op3_reg[k];
        end
        for (int k = 0; k < 2*N_OPS; k++)
            prod_next[k] = (PW'(phi_reg[k]) <<< LO_W) + PW'(plo_reg[k]);
        for (int k = 0; k < N_OPS; k++)
            pair_next[k] = SUM2_W'(prod_reg[2*k]) + SUM2_W'(prod_reg[2*k + 1]);
    end

    // round half up, shift, saturate
    assign sum_v    = SW'(pair_reg[0]) + SW'(pair_reg[1]) + HALF_VAL;
    assign sum_d    = SW'(pair_reg[2]) + SW'(pair_reg[3]) + HALF_SLP;
    assign shv_next = $signed(sum_v[SW-1:VAL_SH]);
    assign shd_next = $signed(sum_d[SW-1:SLP_SH]);
    assign out_next = {sat32(shd_reg), sat32(SAT_W'(shv_reg))};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < N_OPS; k++)
            begin
                op1_reg[k] <= $signed(s_tdata[k*D_W +: D_W]);
                op2_reg[k] <= op1_reg[k];
                op3_reg[k] <= op2_reg[k];
            end
            t1_reg   <= s_tdata[N_OPS*D_W +: T_W];
            tsq1_reg <= tsq_next;
            t2s_reg  <= t1_reg;
            tsq2_reg <= tsq1_reg;
            tcu_reg  <= tcu_next;
            for (int k = 0; k < 2*N_OPS; k++)
            begin
                w_reg[k]    <= w_next[k];
                plo_reg[k]  <= plo_next[k];
                phi_reg[k]  <= phi_next[k];
                prod_reg[k] <= prod_next[k];
            end
            for (int k = 0; k < N_OPS; k++)
                pair_reg[k] <= pair_next[k];
            shv_reg <= shv_next;
            shd_reg <= shd_next;
            out_reg <= out_next;
        end
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (ce && v_reg[STAGES-2]) |=> m_tvalid)
        else $error("beat lost before the output register");

endmodule

// File: dv/hermite_eval_checker.sv
// Checker for the Hermite evaluator: predicts each output beat from the accepted input and compares.
`timescale 1ns / 1ps

module hermite_eval_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [che_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [che_pkg::OUT_W-1:0] m_tdata,
    output int                        mismatches,
    output int                        pending,
    output int                        compared
);
    import che_pkg::*;

    typedef struct packed {
        logic [D_W-1:0] slope;
        logic [D_W-1:0] value;
    } curve_sample_t;

    localparam logic signed [127:0] POS_LIM = 128'sd2147483647;
    localparam logic signed [127:0] NEG_LIM = -128'sd2147483648;

    curve_sample_t samples_due[$];

    function automatic logic [D_W-1:0] round_saturate(input logic signed [127:0] acc,
                                                      input int sh);
        logic signed [127:0] half;
        logic signed [127:0] r;
        logic [D_W-1:0]      q;
        half = 128'sd1 <<< (sh - 1);
        r = (acc + half) >>> sh;
        if (r > POS_LIM)
            q = 32'h7fff_ffff;
        else if (r < NEG_LIM)
            q = 32'h8000_0000;
        else
            q = r[D_W-1:0];
        return q;
    endfunction

    function automatic curve_sample_t eval_segment(input logic [IN_W-1:0] d);
        logic signed [127:0] p0, m0, m1, p1, t, s, t2, t3;
        logic signed [127:0] h00, h01, h10, h11, d00, d01, d10, d11;
        logic signed [127:0] pos_acc, slope_acc;
        curve_sample_t r;
        p0 = $signed(d[D_W-1:0]);
        m0 = $signed(d[2*D_W-1:D_W]);
        m1 = $signed(d[3*D_W-1:2*D_W]);
        p1 = $signed(d[4*D_W-1:3*D_W]);
        t  = {112'd0, d[N_OPS*D_W +: T_W]};
        s  = 128'sd32768;
        t2 = t * t;
        t3 = t2 * t;
        h00 = 2 * t3 - 3 * t2 * s + s * s * s;
        h01 = -2 * t3 + 3 * t2 * s;
        h10 = t3 - 2 * t2 * s + t * s * s;
        h11 = t3 - t2 * s;
        d00 = 6 * t2 - 6 * t * s;
        d01 = -d00;
        d10 = 3 * t2 - 4 * t * s + s * s;
        d11 = 3 * t2 - 2 * t * s;
        pos_acc   = h00 * p0 + h10 * m0 + h11 * m1 + h01 * p1;
        slope_acc = d00 * p0 + d10 * m0 + d11 * m1 + d01 * p1;
        r.value = round_saturate(pos_acc, VAL_SH);
        r.slope = round_saturate(slope_acc, SLP_SH);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_sample_t want;
        curve_sample_t got;
        if (!rst_n)
        begin
            mismatches <= 0;
            pending    <= 0;
            compared   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (samples_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: output beat %h with nothing outstanding", $time, m_tdata);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = samples_due.pop_front();
                    if (want.value !== got.value || want.slope !== got.slope)
                    begin
                        if (mismatches < 10)
                            $display("%0t: beat %0d value exp %h got %h, slope exp %h got %h",
                                     $time, compared, want.value, got.value,
                                     want.slope, got.slope);
                        mismatches <= mismatches + 1;
                    end
                    compared <= compared + 1;
                end
            end
            if (s_tvalid && s_tready)
                samples_due.push_back(eval_segment(s_tdata));
            pending <= samples_due.size();
        end
    end

endmodule

// File: dv/testbench.sv
// Top of the Hermite evaluator testbench: clock, reset, stimulus, sink stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import che_pkg::*;

    localparam int RAND_ITEMS  = 900;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int compared;
    int beats_sent = 0;
    bit calm = 1'b0;
    bit hold_done = 1'b0;

    cubic_hermite_eval_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hermite_eval_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [IN_W-1:0] pack_segment(input logic [D_W-1:0] p0,
                                                     input logic [D_W-1:0] m0,
                                                     input logic [D_W-1:0] m1,
                                                     input logic [D_W-1:0] p1,
                                                     input logic [T_W-1:0] t);
        return {t, p1, m1, m0, p0};
    endfunction

    function automatic logic [D_W-1:0] rand_coord();
        logic [D_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'h8000_0000;
            1: w = 32'h7fff_ffff;
            2: w = '0;
            3, 4: w = $urandom();
            default: w = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        endcase
        return w;
    endfunction

    function automatic logic [T_W-1:0] rand_t();
        logic [T_W-1:0] t;
        case ($urandom_range(0, 9))
            0: t = '0;
            1: t = 16'd32768;
            2: t = T_W'($urandom());
            default: t = T_W'($urandom_range(0, 32768));
        endcase
        return t;
    endfunction

    task automatic send_beat(input logic [IN_W-1:0] d);
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic idle_source(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_outstanding();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 5) == 0)
            idle_source($urandom_range(1, 12));
    endtask

    // sink: random stalls, one long hold-off once the pipeline has traffic
    initial
    begin : sink_proc
        int gap;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && beats_sent >= 300)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                gap = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(pack_segment(32'h0, 32'h0, 32'h0, 32'h0, 16'd0));
        send_beat(pack_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               16'd0));
        send_beat(pack_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               16'd32768));
        maybe_idle();
        send_beat(pack_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               16'hffff));
        send_beat(pack_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               16'hffff));
        send_beat(pack_segment(32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff, 16'd16384));
        send_beat(pack_segment(32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000, 16'd16384));
        maybe_idle();
        send_beat(pack_segment(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0003_0000,
                               16'd32769));
        send_beat(pack_segment(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0003_0000,
                               16'd1));
        send_beat(pack_segment(32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'd32767));
        send_beat(pack_segment(32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'd8192));
        send_beat(pack_segment(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001,
                               16'd16384));
        maybe_idle();
        send_beat(pack_segment(32'h0010_0000, 32'h0, 32'h0, 32'h0020_0000, 16'd49152));
        send_beat(pack_segment(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 32'h8765_4321,
                               16'd24576));
        send_beat(pack_segment(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                               16'h5555));
        send_beat(pack_segment(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                               16'haaaa));
        drain_outstanding();

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            calm = (i >= RAND_ITEMS - CALM_ITEMS);
            if (i == 600)
                drain_outstanding();
            send_beat(pack_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                   rand_t()));
            maybe_idle();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * STAGES) @(posedge clk);

        $display("%0d segment beats driven, %0d value/slope results compared", beats_sent,
                 compared);
        $display("covered t at 0, 1 and beyond, saturating extremes, %0d-cycle sink hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
